>>> design/bmp_pixel_color_classifier_assert.svh
// assertion macros used by the bitmap pixel classifier top level
`ifndef BMP_PIXEL_COLOR_CLASSIFIER_ASSERT_SVH
`define BMP_PIXEL_COLOR_CLASSIFIER_ASSERT_SVH

// property that must hold at every clock edge outside reset
`define BPCC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// condition that must never be seen outside reset
`define BPCC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

>>> design/bpcc_pkg.sv
// shared types, constants and helpers of the bitmap pixel classifier
package bpcc_pkg;

  localparam int DEF_MAX_WIDTH     = 1024;
  localparam int DEF_MAX_HEIGHT    = 1024;
  localparam int DEF_PALETTE_DEPTH = 256;

  localparam int BYTE_W     = 8;
  localparam int CLASS_W    = 2;
  localparam int COORD_W    = 10;
  localparam int DIM_W      = 11;
  localparam int PCOUNT_W   = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;
  localparam int MAX_PIX    = 8;
  localparam int PIX_CNT_W  = 4;

  // palette size used when the count register holds zero
  localparam logic [PCOUNT_W-1:0] PAL_DEF_4BIT = 9'd16;
  localparam logic [PCOUNT_W-1:0] PAL_DEF_8BIT = 9'd256;

  localparam logic [BYTE_W-1:0] LEVEL_FULL = 8'hFF;
  localparam logic [BYTE_W-1:0] LEVEL_NONE = 8'h00;

  typedef enum logic [1:0] {
    DEPTH_1BIT  = 2'd0,
    DEPTH_4BIT  = 2'd1,
    DEPTH_8BIT  = 2'd2,
    DEPTH_24BIT = 2'd3
  } depth_e;

  typedef enum logic [CLASS_W-1:0] {
    CLS_WHITE = 2'd0,
    CLS_RED   = 2'd1,
    CLS_BLACK = 2'd2
  } pix_class_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEPTH_MODE    = 3'd0,
    REG_IMAGE_WIDTH   = 3'd1,
    REG_IMAGE_HEIGHT  = 3'd2,
    REG_PALETTE_COUNT = 3'd3
  } cfg_reg_e;

  typedef enum logic {
    REQ_PALETTE = 1'b0,
    REQ_PIXEL   = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    PH_BLUE  = 2'd0,
    PH_GREEN = 2'd1,
    PH_RED   = 2'd2
  } rgb_phase_e;

  // pixels produced by one data byte, oldest in slot 0
  typedef struct packed {
    logic [MAX_PIX-1:0][CLASS_W-1:0] cls;
    logic [MAX_PIX-1:0]              err;
    logic [PIX_CNT_W-1:0]            cnt;
    logic [COORD_W-1:0]              row;
    logic [COORD_W-1:0]              col;
    logic                            fe;
    logic                            err_sum;
  } batch_t;

  function automatic pix_class_e classify(input logic [BYTE_W-1:0] b,
                                          input logic [BYTE_W-1:0] g,
                                          input logic [BYTE_W-1:0] r);
    pix_class_e res;
    if (b == LEVEL_FULL && g == LEVEL_FULL && r == LEVEL_FULL) begin
      res = CLS_WHITE;
    end else if (b == LEVEL_NONE && g == LEVEL_NONE && r == LEVEL_FULL) begin
      res = CLS_RED;
    end else begin
      res = CLS_BLACK;
    end
    return res;
  endfunction

endpackage

>>> design/bpcc_in_if.sv
// input channel: palette loads and pixel array bytes
interface bpcc_in_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [bpcc_pkg::BYTE_W-1:0]   palette_index;
  logic [bpcc_pkg::BYTE_W-1:0]   entry_blue;
  logic [bpcc_pkg::BYTE_W-1:0]   entry_green;
  logic [bpcc_pkg::BYTE_W-1:0]   entry_red;
  logic [bpcc_pkg::BYTE_W-1:0]   data_byte;

  modport source (
    output valid, req_type, palette_index, entry_blue, entry_green, entry_red, data_byte,
    input  ready
  );
  modport sink (
    input  valid, req_type, palette_index, entry_blue, entry_green, entry_red, data_byte,
    output ready
  );
endinterface

>>> design/bpcc_out_if.sv
// output channel: one classified pixel per transaction
interface bpcc_out_if;
  logic                          valid;
  logic                          ready;
  logic [bpcc_pkg::CLASS_W-1:0]  pixel_class;
  logic [bpcc_pkg::COORD_W-1:0]  out_row;
  logic [bpcc_pkg::COORD_W-1:0]  out_column;
  logic                          last;
  logic                          frame_end;
  logic                          index_error;

  modport source (
    output valid, pixel_class, out_row, out_column, last, frame_end, index_error,
    input  ready
  );
  modport sink (
    input  valid, pixel_class, out_row, out_column, last, frame_end, index_error,
    output ready
  );
endinterface

>>> design/bpcc_cfg_if.sv
// configuration write channel
interface bpcc_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [bpcc_pkg::CFG_IDX_W-1:0]    reg_index;
  logic [bpcc_pkg::CFG_DATA_W-1:0]   wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

>>> design/bpcc_palette.sv
// palette memory holding the class of each loaded entry, two registered read ports
module bpcc_palette #(
  parameter int PALETTE_DEPTH = bpcc_pkg::DEF_PALETTE_DEPTH,
  localparam int PIW = $clog2(PALETTE_DEPTH)
) (
  input  logic                                 clk_i,
  input  logic                                 wr_en_i,
  input  logic [PIW-1:0]                       wr_addr_i,
  input  logic [bpcc_pkg::BYTE_W-1:0]          blue_i,
  input  logic [bpcc_pkg::BYTE_W-1:0]          green_i,
  input  logic [bpcc_pkg::BYTE_W-1:0]          red_i,
  input  logic                                 rd_en_i,
  input  logic [1:0][PIW-1:0]                  rd_addr_i,
  output logic [1:0][bpcc_pkg::CLASS_W-1:0]    rd_cls_o
);

  logic [bpcc_pkg::CLASS_W-1:0] mem_q [PALETTE_DEPTH];
  logic [1:0][bpcc_pkg::CLASS_W-1:0] rd_q;

  // entries are stored already classified
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= bpcc_pkg::classify(blue_i, green_i, red_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q[0] <= mem_q[rd_addr_i[0]];
      rd_q[1] <= mem_q[rd_addr_i[1]];
    end
  end

  assign rd_cls_o = rd_q;

endmodule

>>> design/bpcc_serializer.sv
// output stage that hands out the pixels of one byte, one per transaction
module bpcc_serializer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  bpcc_pkg::batch_t     batch_i,
  bpcc_out_if.source           pix_o
);

  logic             valid_q, valid_d;
  bpcc_pkg::batch_t cur_q, cur_d;
  logic             emit;
  logic             last_pix;

  assign last_pix = (cur_q.cnt == bpcc_pkg::PIX_CNT_W'(1));
  assign emit     = valid_q && pix_o.ready;
  assign ready_o  = !valid_q || (emit && last_pix);

  always_comb begin
    cur_d   = cur_q;
    valid_d = valid_q;
    if (emit) begin
      cur_d.cls = {{bpcc_pkg::CLASS_W{1'b0}}, cur_q.cls[bpcc_pkg::MAX_PIX-1:1]};
      cur_d.err = {1'b0, cur_q.err[bpcc_pkg::MAX_PIX-1:1]};
      cur_d.cnt = cur_q.cnt - bpcc_pkg::PIX_CNT_W'(1);
      cur_d.col = cur_q.col + bpcc_pkg::COORD_W'(1);
      if (last_pix) begin
        valid_d = 1'b0;
      end
    end
    if (valid_i && ready_o) begin
      cur_d   = batch_i;
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  assign pix_o.valid       = valid_q;
  assign pix_o.pixel_class = cur_q.cls[0];
  assign pix_o.out_row     = cur_q.row;
  assign pix_o.out_column  = cur_q.col;
  assign pix_o.last        = last_pix;
  assign pix_o.frame_end   = cur_q.fe && last_pix;
  assign pix_o.index_error = cur_q.err[0] || (cur_q.fe && last_pix && cur_q.err_sum);

endmodule

>>> design/bmp_pixel_color_classifier.sv
// top level of the bitmap pixel classifier
// Takes the pixel array of a bitmap (bottom row first, rows padded to four bytes) one byte
// per transaction at 1, 4, 8 or 24 bits per pixel and returns one transaction per pixel with
// its class (white, red, black), its top-down row and its column; padding bytes and the first
// two bytes of a 24-bit pixel give nothing. Palette loads share the input channel and store
// the class of each entry; a palette index at or above the effective count gives black with
// index_error set, and the frame_end pixel also reports whether any pixel of the frame was
// bad. The output stage hands out one pixel per cycle while the output is ready, and a
// byte yields up to eight pixels in 1-bit mode, two in 4-bit mode and one otherwise; the
// stage takes the next byte as it hands out the last pixel of the current one. A byte is
// accepted each cycle while the output keeps up; the first pixel of a byte passes the byte
// decode register (where the palette read also lands) and then the output stage register.
// The palette is not cleared at reset: load every entry that a frame uses. A write to one
// of the four registers restarts the frame but keeps the palette; write configuration
// only while the block is idle.
`include "bmp_pixel_color_classifier_assert.svh"

module bmp_pixel_color_classifier #(
  parameter int MAX_WIDTH     = bpcc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT    = bpcc_pkg::DEF_MAX_HEIGHT,
  parameter int PALETTE_DEPTH = bpcc_pkg::DEF_PALETTE_DEPTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  bpcc_cfg_if.sink     cfg_i,
  bpcc_in_if.sink      pix_i,
  bpcc_out_if.source   pix_o
);

  localparam int CW   = $clog2(MAX_WIDTH + 1);
  localparam int RWD  = $clog2(MAX_HEIGHT + 1);
  localparam int BC_W = $clog2(3 * MAX_WIDTH + 4);
  localparam int PIW  = $clog2(PALETTE_DEPTH);

  // configuration registers
  bpcc_pkg::depth_e                  depth_q, depth_d;
  logic [bpcc_pkg::DIM_W-1:0]        width_q, width_d;
  logic [bpcc_pkg::DIM_W-1:0]        height_q, height_d;
  logic [bpcc_pkg::PCOUNT_W-1:0]     pcount_q, pcount_d;
  logic                              cfg_we;
  logic                              cfg_hit;

  // frame position state
  logic [RWD-1:0]                    row_q, row_d;
  logic [CW-1:0]                     col_q, col_d;
  logic [BC_W-1:0]                   rbc_q, rbc_d;
  logic [2*bpcc_pkg::BYTE_W-1:0]     hold_q, hold_d;
  bpcc_pkg::rgb_phase_e              phase_q, phase_d;
  logic                              err_latch_q, err_latch_d;

  // derived geometry
  logic [CW-1:0]                     w;
  logic [CW-1:0]                     room;
  logic [RWD-1:0]                    h;
  logic [BC_W-1:0]                   wb, db, stride, rbc_inc;
  logic [bpcc_pkg::PCOUNT_W-1:0]     pcnt_base, pcnt_eff;

  // byte decode
  logic                              in_acc;
  logic                              is_pix;
  logic                              in_zone;
  logic                              rgb_fire;
  logic [bpcc_pkg::BYTE_W-1:0]       data_b;
  logic [3:0]                        idx_hi, idx_lo;
  logic [bpcc_pkg::PIX_CNT_W-1:0]    n_pix;
  logic [bpcc_pkg::MAX_PIX-1:0]      pix_mask, err_raw, err_pix;
  logic                              err_any;
  logic [bpcc_pkg::MAX_PIX-1:0][bpcc_pkg::CLASS_W-1:0] cls_pre;

  // decode register and hand-off to the output stage
  logic                              s1_valid_q, s1_valid_d;
  bpcc_pkg::batch_t                  s1_q, s1_d;
  logic                              s1_pal_q;
  logic                              s1_load;
  logic                              ser_ready;
  bpcc_pkg::batch_t                  ser_batch;

  // palette ports
  logic                              pal_we;
  logic [1:0][PIW-1:0]               pal_raddr;
  logic [1:0][bpcc_pkg::CLASS_W-1:0] pal_rcls;

  // ---------------------------------------------------------------------------------------
  // configuration port, always ready
  // ---------------------------------------------------------------------------------------
  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid && cfg_i.ready;

  always_comb begin
    depth_d  = depth_q;
    width_d  = width_q;
    height_d = height_q;
    pcount_d = pcount_q;
    cfg_hit  = 1'b0;
    if (cfg_we) begin
      case (cfg_i.reg_index)
        bpcc_pkg::REG_DEPTH_MODE: begin
          depth_d = bpcc_pkg::depth_e'(cfg_i.wdata[1:0]);
          cfg_hit = 1'b1;
        end
        bpcc_pkg::REG_IMAGE_WIDTH: begin
          width_d = cfg_i.wdata;
          cfg_hit = 1'b1;
        end
        bpcc_pkg::REG_IMAGE_HEIGHT: begin
          height_d = cfg_i.wdata;
          cfg_hit  = 1'b1;
        end
        bpcc_pkg::REG_PALETTE_COUNT: begin
          pcount_d = cfg_i.wdata[bpcc_pkg::PCOUNT_W-1:0];
          cfg_hit  = 1'b1;
        end
        default: begin
          // unknown index: write dropped, frame kept
          cfg_hit = 1'b0;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------------------
  // geometry: zero dimension means one, oversize saturates
  // ---------------------------------------------------------------------------------------
  always_comb begin
    if (width_q == '0) begin
      w = CW'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w = CW'(MAX_WIDTH);
    end else begin
      w = CW'(width_q);
    end
    if (height_q == '0) begin
      h = RWD'(1);
    end else if (32'(height_q) > MAX_HEIGHT) begin
      h = RWD'(MAX_HEIGHT);
    end else begin
      h = RWD'(height_q);
    end
  end

  // data bytes per row, then the stride rounded up to four bytes
  assign wb = BC_W'(w);

  always_comb begin
    case (depth_q)
      bpcc_pkg::DEPTH_1BIT:  db = (wb + BC_W'(7)) >> 3;
      bpcc_pkg::DEPTH_4BIT:  db = (wb + BC_W'(1)) >> 1;
      bpcc_pkg::DEPTH_8BIT:  db = wb;
      default:               db = wb + (wb << 1);
    endcase
  end

  assign stride  = (db + BC_W'(3)) & ~BC_W'(3);
  assign rbc_inc = rbc_q + BC_W'(1);
  assign in_zone = (rbc_q < db);
  assign room    = w - col_q;

  // effective palette count, capped at the memory depth
  always_comb begin
    if (pcount_q == '0) begin
      pcnt_base = (depth_q == bpcc_pkg::DEPTH_4BIT) ? bpcc_pkg::PAL_DEF_4BIT
                                                    : bpcc_pkg::PAL_DEF_8BIT;
    end else begin
      pcnt_base = pcount_q;
    end
    if (32'(pcnt_base) > PALETTE_DEPTH) begin
      pcnt_eff = bpcc_pkg::PCOUNT_W'(PALETTE_DEPTH);
    end else begin
      pcnt_eff = pcnt_base;
    end
  end

  // ---------------------------------------------------------------------------------------
  // byte decode: how many pixels, their classes and index errors
  // ---------------------------------------------------------------------------------------
  assign in_acc   = pix_i.valid && pix_i.ready;
  assign is_pix   = (pix_i.req_type == bpcc_pkg::REQ_PIXEL);
  assign data_b   = pix_i.data_byte;
  assign idx_hi   = data_b[7:4];
  assign idx_lo   = data_b[3:0];
  assign rgb_fire = (phase_q == bpcc_pkg::PH_RED);

  always_comb begin
    n_pix = '0;
    if (in_zone) begin
      case (depth_q)
        bpcc_pkg::DEPTH_1BIT: begin
          // pixels past the row width are dropped
          n_pix = (room >= CW'(8)) ? bpcc_pkg::PIX_CNT_W'(8) : bpcc_pkg::PIX_CNT_W'(room);
        end
        bpcc_pkg::DEPTH_4BIT: begin
          if (room >= CW'(2)) begin
            n_pix = bpcc_pkg::PIX_CNT_W'(2);
          end else if (room != '0) begin
            n_pix = bpcc_pkg::PIX_CNT_W'(1);
          end
        end
        bpcc_pkg::DEPTH_8BIT: begin
          if (room != '0) begin
            n_pix = bpcc_pkg::PIX_CNT_W'(1);
          end
        end
        default: begin
          if (rgb_fire && room != '0) begin
            n_pix = bpcc_pkg::PIX_CNT_W'(1);
          end
        end
      endcase
    end
  end

  always_comb begin
    for (int j = 0; j < bpcc_pkg::MAX_PIX; j++) begin
      pix_mask[j] = (bpcc_pkg::PIX_CNT_W'(j) < n_pix);
    end
  end

  always_comb begin
    err_raw = '0;
    case (depth_q)
      bpcc_pkg::DEPTH_4BIT: begin
        err_raw[0] = (bpcc_pkg::PCOUNT_W'(idx_hi) >= pcnt_eff);
        err_raw[1] = (bpcc_pkg::PCOUNT_W'(idx_lo) >= pcnt_eff);
      end
      bpcc_pkg::DEPTH_8BIT: begin
        err_raw[0] = (bpcc_pkg::PCOUNT_W'(data_b) >= pcnt_eff);
      end
      default: begin
        err_raw = '0;
      end
    endcase
  end

  assign err_pix = err_raw & pix_mask;
  assign err_any = |err_pix;

  // classes that need no palette: 1-bit pixels msb first, 24-bit triplets
  always_comb begin
    cls_pre = '0;
    case (depth_q)
      bpcc_pkg::DEPTH_1BIT: begin
        for (int j = 0; j < bpcc_pkg::MAX_PIX; j++) begin
          cls_pre[j] = data_b[bpcc_pkg::MAX_PIX-1-j] ? bpcc_pkg::CLS_WHITE
                                                     : bpcc_pkg::CLS_BLACK;
        end
      end
      bpcc_pkg::DEPTH_24BIT: begin
        cls_pre[0] = bpcc_pkg::classify(hold_q[7:0], hold_q[15:8], data_b);
      end
      default: begin
        cls_pre = '0;
      end
    endcase
  end

  // batch for the decode register
  always_comb begin
    s1_d.cls     = cls_pre;
    s1_d.err     = err_pix;
    s1_d.cnt     = n_pix;
    s1_d.row     = bpcc_pkg::COORD_W'(h - RWD'(1) - row_q);
    s1_d.col     = bpcc_pkg::COORD_W'(col_q);
    s1_d.fe      = ((col_q + CW'(n_pix)) == w) && (row_q == h - RWD'(1));
    s1_d.err_sum = err_latch_q | err_any;
  end

  // ---------------------------------------------------------------------------------------
  // frame position update, one step per accepted pixel array byte
  // ---------------------------------------------------------------------------------------
  always_comb begin
    row_d       = row_q;
    col_d       = col_q;
    rbc_d       = rbc_q;
    hold_d      = hold_q;
    phase_d     = phase_q;
    err_latch_d = err_latch_q;
    if (cfg_hit) begin
      // any register write restarts the frame
      row_d       = '0;
      col_d       = '0;
      rbc_d       = '0;
      hold_d      = '0;
      phase_d     = bpcc_pkg::PH_BLUE;
      err_latch_d = 1'b0;
    end else if (in_acc && is_pix) begin
      col_d       = col_q + CW'(n_pix);
      err_latch_d = err_latch_q | err_any;
      rbc_d       = rbc_inc;
      if (in_zone && depth_q == bpcc_pkg::DEPTH_24BIT) begin
        case (phase_q)
          bpcc_pkg::PH_BLUE: begin
            hold_d  = {bpcc_pkg::LEVEL_NONE, data_b};
            phase_d = bpcc_pkg::PH_GREEN;
          end
          bpcc_pkg::PH_GREEN: begin
            hold_d  = {data_b, hold_q[7:0]};
            phase_d = bpcc_pkg::PH_RED;
          end
          default: begin
            phase_d = bpcc_pkg::PH_BLUE;
          end
        endcase
      end
      // end of row after its last padding byte
      if (rbc_inc >= stride) begin
        rbc_d   = '0;
        col_d   = '0;
        hold_d  = '0;
        phase_d = bpcc_pkg::PH_BLUE;
        if (row_q + RWD'(1) >= h) begin
          row_d       = '0;
          err_latch_d = 1'b0;
        end else begin
          row_d = row_q + RWD'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q     <= bpcc_pkg::DEPTH_1BIT;
      width_q     <= bpcc_pkg::DIM_W'(1);
      height_q    <= bpcc_pkg::DIM_W'(1);
      pcount_q    <= '0;
      row_q       <= '0;
      col_q       <= '0;
      rbc_q       <= '0;
      hold_q      <= '0;
      phase_q     <= bpcc_pkg::PH_BLUE;
      err_latch_q <= 1'b0;
    end else begin
      depth_q     <= depth_d;
      width_q     <= width_d;
      height_q    <= height_d;
      pcount_q    <= pcount_d;
      row_q       <= row_d;
      col_q       <= col_d;
      rbc_q       <= rbc_d;
      hold_q      <= hold_d;
      phase_q     <= phase_d;
      err_latch_q <= err_latch_d;
    end
  end

  // ---------------------------------------------------------------------------------------
  // palette: loads write, pixel bytes read both nibble slots in the accept cycle
  // ---------------------------------------------------------------------------------------
  assign pal_we       = in_acc && !is_pix && (32'(pix_i.palette_index) < PALETTE_DEPTH);
  assign pal_raddr[0] = (depth_q == bpcc_pkg::DEPTH_4BIT) ? PIW'(idx_hi) : PIW'(data_b);
  assign pal_raddr[1] = PIW'(idx_lo);

  bpcc_palette #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk_i     (clk_i),
    .wr_en_i   (pal_we),
    .wr_addr_i (PIW'(pix_i.palette_index)),
    .blue_i    (pix_i.entry_blue),
    .green_i   (pix_i.entry_green),
    .red_i     (pix_i.entry_red),
    .rd_en_i   (in_acc && is_pix),
    .rd_addr_i (pal_raddr),
    .rd_cls_o  (pal_rcls)
  );

  // ---------------------------------------------------------------------------------------
  // decode register: only bytes that yield pixels occupy it
  // ---------------------------------------------------------------------------------------
  assign s1_load     = in_acc && is_pix && (n_pix != '0);
  assign pix_i.ready = !s1_valid_q || ser_ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_load) begin
      s1_valid_d = 1'b1;
    end else if (s1_valid_q && ser_ready) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_q     <= s1_d;
      s1_pal_q <= (depth_q == bpcc_pkg::DEPTH_4BIT) || (depth_q == bpcc_pkg::DEPTH_8BIT);
    end
  end

  // palette classes join here; a bad index forces black
  always_comb begin
    ser_batch = s1_q;
    if (s1_pal_q) begin
      ser_batch.cls[0] = s1_q.err[0] ? bpcc_pkg::CLS_BLACK : pal_rcls[0];
      ser_batch.cls[1] = s1_q.err[1] ? bpcc_pkg::CLS_BLACK : pal_rcls[1];
    end
  end

  bpcc_serializer u_serializer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid_q),
    .ready_o (ser_ready),
    .batch_i (ser_batch),
    .pix_o   (pix_o)
  );

  // ---------------------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------------------
  `BPCC_ASSERT(a_load_no_batch,
    (in_acc && pix_i.req_type == bpcc_pkg::REQ_PALETTE) |=> !s1_valid_q,
    "palette load left a pixel batch behind")
  `BPCC_ASSERT(a_burst_continues,
    (pix_o.valid && pix_o.ready && !pix_o.last) |=> pix_o.valid,
    "pixel burst of one byte broke off before its last pixel")
  `BPCC_ASSERT(a_frame_end_last,
    (pix_o.valid && pix_o.frame_end) |-> pix_o.last,
    "frame end flagged on a pixel that does not close its byte")
  `BPCC_ASSERT_NEVER(a_col_in_row,
    col_q > w,
    "column counter ran past the row width")

endmodule

>>> tb/bpcc_tb_pkg.sv
// transaction types and pixel scoreboard for the bitmap pixel classifier testbench
package bpcc_tb_pkg;
  import bpcc_pkg::*;

  typedef struct {
    req_e              kind;
    logic [BYTE_W-1:0] slot;
    logic [BYTE_W-1:0] blue;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] data;
  } pix_req_t;

  typedef struct {
    logic [CLASS_W-1:0] cls;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               last;
    logic               frame_end;
    logic               index_error;
  } pixel_t;

  class bitmap_row_predictor;
    // register copies
    depth_e      depth;
    int unsigned width_reg;
    int unsigned height_reg;
    int unsigned pcount_reg;

    // decode state
    logic [CLASS_W-1:0] pal_cls [DEF_PALETTE_DEPTH];
    int unsigned        row_cnt;
    int unsigned        col_cnt;
    int unsigned        byte_cnt;
    logic [15:0]        rgb_hold;
    rgb_phase_e         rgb_phase;
    bit                 err_latched;

    pixel_t      byte_pixels[$];
    pixel_t      expected_pixels[$];
    int unsigned pixels_checked;
    int unsigned frame_ends;
    int unsigned bad_indexes;
    int unsigned mismatches;

    function new();
      depth      = DEPTH_1BIT;
      width_reg  = 1;
      height_reg = 1;
      pcount_reg = 0;
      foreach (pal_cls[i]) pal_cls[i] = CLS_WHITE;
      pixels_checked = 0;
      frame_ends     = 0;
      bad_indexes    = 0;
      mismatches     = 0;
      restart();
    endfunction

    function void restart();
      row_cnt     = 0;
      col_cnt     = 0;
      byte_cnt    = 0;
      rgb_hold    = '0;
      rgb_phase   = PH_BLUE;
      err_latched = 1'b0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_DEPTH_MODE:    depth = depth_e'(value[1:0]);
        REG_IMAGE_WIDTH:   width_reg = value;
        REG_IMAGE_HEIGHT:  height_reg = value;
        REG_PALETTE_COUNT: pcount_reg = value[PCOUNT_W-1:0];
        default:           return;
      endcase
      restart();
    endfunction

    function int unsigned eff_width();
      if (width_reg == 0) return 1;
      return (width_reg > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : width_reg;
    endfunction

    function int unsigned eff_height();
      if (height_reg == 0) return 1;
      return (height_reg > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : height_reg;
    endfunction

    function int unsigned data_bytes();
      case (depth)
        DEPTH_1BIT: return (eff_width() + 7) / 8;
        DEPTH_4BIT: return (eff_width() + 1) / 2;
        DEPTH_8BIT: return eff_width();
        default:    return 3 * eff_width();
      endcase
    endfunction

    function int unsigned row_stride();
      return (data_bytes() + 3) / 4 * 4;
    endfunction

    function int unsigned frame_bytes();
      return row_stride() * eff_height();
    endfunction

    function logic [CLASS_W-1:0] color_class(logic [7:0] b, logic [7:0] g, logic [7:0] r);
      if (b == 8'hFF && g == 8'hFF && r == 8'hFF) return CLS_WHITE;
      if (b == 8'h00 && g == 8'h00 && r == 8'hFF) return CLS_RED;
      return CLS_BLACK;
    endfunction

    function void add_pixel(logic [CLASS_W-1:0] cls, bit bad);
      pixel_t p;
      bit     fe;
      fe = (col_cnt == eff_width() - 1) && (row_cnt == eff_height() - 1);
      if (bad) err_latched = 1'b1;
      p.cls         = cls;
      p.row         = COORD_W'(eff_height() - 1 - row_cnt);
      p.col         = COORD_W'(col_cnt);
      p.last        = 1'b0;
      p.frame_end   = fe;
      p.index_error = bad || (fe && err_latched);
      byte_pixels.push_back(p);
      col_cnt++;
    endfunction

    function void palette_pixel(int unsigned idx);
      int unsigned cnt;
      cnt = pcount_reg;
      if (cnt == 0) cnt = (depth == DEPTH_4BIT) ? PAL_DEF_4BIT : PAL_DEF_8BIT;
      if (cnt > DEF_PALETTE_DEPTH) cnt = DEF_PALETTE_DEPTH;
      if (idx >= cnt) add_pixel(CLS_BLACK, 1'b1);
      else add_pixel(pal_cls[idx], 1'b0);
    endfunction

    // accepted input transaction: palette load or pixel array byte
    function void note_transaction(pix_req_t t);
      int unsigned w;
      int unsigned db;
      if (t.kind == REQ_PALETTE) begin
        pal_cls[t.slot] = color_class(t.blue, t.green, t.red);
        return;
      end
      w  = eff_width();
      db = data_bytes();
      if (row_cnt >= eff_height()) row_cnt = 0;
      byte_pixels.delete();
      if (byte_cnt < db) begin
        case (depth)
          DEPTH_1BIT: begin
            for (int k = 7; k >= 0; k--) begin
              if (col_cnt >= w) break;
              add_pixel(t.data[k] ? CLS_WHITE : CLS_BLACK, 1'b0);
            end
          end
          DEPTH_4BIT: begin
            if (col_cnt < w) palette_pixel(t.data[7:4]);
            if (col_cnt < w) palette_pixel(t.data[3:0]);
          end
          DEPTH_8BIT: begin
            if (col_cnt < w) palette_pixel(t.data);
          end
          default: begin
            case (rgb_phase)
              PH_BLUE: begin
                rgb_hold  = {8'h00, t.data};
                rgb_phase = PH_GREEN;
              end
              PH_GREEN: begin
                rgb_hold[15:8] = t.data;
                rgb_phase      = PH_RED;
              end
              default: begin
                if (col_cnt < w) add_pixel(color_class(rgb_hold[7:0], rgb_hold[15:8], t.data),
                                           1'b0);
                rgb_phase = PH_BLUE;
              end
            endcase
          end
        endcase
      end
      byte_cnt++;
      if (byte_cnt >= row_stride()) begin
        byte_cnt  = 0;
        col_cnt   = 0;
        rgb_phase = PH_BLUE;
        rgb_hold  = '0;
        row_cnt++;
        if (row_cnt >= eff_height()) begin
          row_cnt     = 0;
          err_latched = 1'b0;
        end
      end
      if (byte_pixels.size() > 0) byte_pixels[byte_pixels.size() - 1].last = 1'b1;
      foreach (byte_pixels[i]) expected_pixels.push_back(byte_pixels[i]);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (expected_pixels.size() == 0) begin
        $error("unexpected pixel: row %0d column %0d", got.row, got.col);
        mismatches++;
        return;
      end
      want = expected_pixels.pop_front();
      compare_field("pixel_class", want.cls, got.cls);
      compare_field("out_row", want.row, got.row);
      compare_field("out_column", want.col, got.col);
      compare_field("last", want.last, got.last);
      compare_field("frame_end", want.frame_end, got.frame_end);
      compare_field("index_error", want.index_error, got.index_error);
      pixels_checked++;
      if (got.frame_end) frame_ends++;
      if (got.index_error) bad_indexes++;
    endfunction
  endclass

endpackage

>>> tb/tb.sv
// top-level testbench of the bitmap pixel classifier: directed and random frames
module tb;
  import bpcc_pkg::*;
  import bpcc_tb_pkg::*;

  localparam int CLK_PERIOD     = 20;
  localparam int IDLE_PCT       = 18;
  localparam int PIPE_SETTLE    = 4;
  localparam int TAIL_CYCLES    = 8;
  localparam int TIMEOUT_CYCLES = 400000;
  localparam int RANDOM_ITEMS   = 170;

  // register indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

  logic clk_i;
  logic rst_ni;
  bit   steady;   // both sides run without idling while set

  bpcc_cfg_if cfg_if ();
  bpcc_in_if  in_if ();
  bpcc_out_if out_if ();

  bmp_pixel_color_classifier u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .pix_i  (in_if),
    .pix_o  (out_if)
  );

  bitmap_row_predictor pred = new();
  int unsigned         phases;
  int unsigned         random_items;

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // watchdog: far above the slowest legal run
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $error("timeout with %0d pixels still expected", pred.expected_pixels.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // output back-pressure, changed on the falling edge
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_if.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // every output transaction is checked against the oldest predicted pixel
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      pred.check_pixel(pixel_t'{cls: out_if.pixel_class, row: out_if.out_row,
                                col: out_if.out_column, last: out_if.last,
                                frame_end: out_if.frame_end,
                                index_error: out_if.index_error});
    end
  end

  // random color biased toward the two recognized colors and near misses
  function automatic logic [23:0] pick_color();
    logic [23:0] c;
    int          k;
    k = $urandom_range(0, 2);
    case ($urandom_range(0, 4))
      0: c = 24'hFFFFFF;
      1: c = 24'hFF0000;
      2: begin
        c = 24'hFFFFFF;
        c[8*k +: 8] = 8'($urandom_range(0, 254));
      end
      3: c = 24'hFF0000 ^ (24'h1 << $urandom_range(0, 23));
      default: c = 24'($urandom);
    endcase
    return c;
  endfunction

  function automatic pix_req_t palette_req(logic [BYTE_W-1:0] slot);
    pix_req_t t;
    t.kind = REQ_PALETTE;
    t.slot = slot;
    {t.red, t.green, t.blue} = pick_color();
    t.data = 8'($urandom);
    return t;
  endfunction

  // one input transaction; valid is left high, the next call or a pause lowers it
  task automatic send_req(input pix_req_t t);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.req_type      <= t.kind;
    in_if.palette_index <= t.slot;
    in_if.entry_blue    <= t.blue;
    in_if.entry_green   <= t.green;
    in_if.entry_red     <= t.red;
    in_if.data_byte     <= t.data;
    do @(posedge clk_i); while (!in_if.ready);
    pred.note_transaction(t);
    @(negedge clk_i);
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] value);
    pix_req_t t;
    t.kind  = REQ_PIXEL;
    t.slot  = 8'($urandom);
    t.blue  = 8'($urandom);
    t.green = 8'($urandom);
    t.red   = 8'($urandom);
    t.data  = value;
    send_req(t);
  endtask

  task automatic send_pads(input int n);
    repeat (n) send_byte(8'($urandom));
  endtask

  // stop sending until every predicted pixel has come out
  task automatic wait_for_pixels(input int settle);
    in_if.valid <= 1'b0;
    while (pred.expected_pixels.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_if.valid     <= 1'b1;
    cfg_if.reg_index <= idx;
    cfg_if.wdata     <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    pred.write_reg(idx, value);
    @(negedge clk_i);
  endtask

  // new setting, written once the block has gone quiet; order of the writes varies
  task automatic configure(input depth_e d, input logic [CFG_DATA_W-1:0] w,
                           input logic [CFG_DATA_W-1:0] h,
                           input logic [CFG_DATA_W-1:0] pc);
    logic [CFG_DATA_W-1:0] vals [4];
    int                    start;
    int                    r;
    wait_for_pixels(PIPE_SETTLE);
    vals[REG_DEPTH_MODE]    = CFG_DATA_W'(d);
    vals[REG_IMAGE_WIDTH]   = w;
    vals[REG_IMAGE_HEIGHT]  = h;
    vals[REG_PALETTE_COUNT] = pc;
    start = $urandom_range(0, 3);
    // a write to an unmapped index must change nothing, not even the frame position
    if ($urandom_range(0, 7) == 0) begin
      cfg_write(CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                CFG_DATA_W'($urandom));
    end
    for (int k = 0; k < 4; k++) begin
      r = (start + k) % 4;
      cfg_write(CFG_IDX_W'(r), vals[r]);
    end
    cfg_if.valid <= 1'b0;
    phases++;
  endtask

  initial begin
    depth_e               d;
    logic [CFG_DATA_W-1:0] w;
    logic [CFG_DATA_W-1:0] h;
    logic [CFG_DATA_W-1:0] pc;
    logic [23:0]           color;
    logic [BYTE_W-1:0]     value;
    int unsigned           phase_no;
    int unsigned           frames;
    int unsigned           total;
    int unsigned           cut_at;
    int unsigned           pos;
    int unsigned           stride;
    int unsigned           data_len;

    rst_ni               = 1'b0;
    steady               = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.reg_index     = '0;
    cfg_if.wdata         = '0;
    in_if.valid          = 1'b0;
    in_if.req_type       = REQ_PALETTE;
    in_if.palette_index  = '0;
    in_if.entry_blue     = '0;
    in_if.entry_green    = '0;
    in_if.entry_red      = '0;
    in_if.data_byte      = '0;
    phases               = 0;
    random_items         = 0;
    color                = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset setting: 1-bit, a single white pixel, then the row padding wraps the frame
    send_byte(8'h80);
    send_pads(3);

    // load every palette slot so no read ever hits an unwritten entry
    for (int s = 0; s < DEF_PALETTE_DEPTH; s++) send_req(palette_req(8'(s)));

    // 1-bit, partial last byte drops the pixels past the width; sender pauses mid-row
    configure(DEPTH_1BIT, 12, 1, 0);
    send_byte(8'hA5);
    wait_for_pixels(0);
    send_byte(8'hF0);
    send_pads(2);

    // 4-bit with default palette size, high nibble first, partial last byte
    configure(DEPTH_4BIT, 3, 1, 0);
    send_byte(8'h0F);
    send_byte(8'hE7);
    send_pads(2);

    // bad index in the first row, clean frame end that still reports the error
    configure(DEPTH_4BIT, 1, 2, 5);
    send_byte(8'h70);
    send_pads(3);
    send_byte(8'h20);
    send_pads(3);

    // 24-bit white then red
    configure(DEPTH_24BIT, 2, 1, 0);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_pads(2);

    // random phases: mostly whole frames with random content, some cut short
    phase_no = 0;
    while (random_items < RANDOM_ITEMS) begin
      cut_at = 0;
      frames = $urandom_range(1, 2);
      pc     = CFG_DATA_W'($urandom_range(1, 255));
      case (phase_no)
        0: begin
          // width above the maximum saturates: one full row of 1024 columns
          d = DEPTH_1BIT; w = 11'd2047; h = 11'd1; frames = 1;
        end
        1: begin
          // height above the maximum saturates: a few rows from the bottom
          d = DEPTH_8BIT; w = 11'd1; h = 11'd2047; pc = 11'd256; frames = 1; cut_at = 12;
        end
        2: begin
          // zero width and height are treated as one
          d = DEPTH_24BIT; w = 11'd0; h = 11'd0;
        end
        default: begin
          d = depth_e'($urandom_range(0, 3));
          w = ($urandom_range(0, 9) == 0) ? CFG_DATA_W'($urandom_range(25, 64))
                                          : CFG_DATA_W'($urandom_range(1, 24));
          h = CFG_DATA_W'($urandom_range(1, 4));
          case ($urandom_range(0, 3))
            0: pc = 11'd0;
            1: pc = 11'd256;
            2: pc = 11'd16;
            default: ;
          endcase
          if ($urandom_range(0, 5) == 0) cut_at = 1;
        end
      endcase
      // the long 1-bit row and the two phases after it run with no idling
      steady = (phase_no < 3);
      configure(d, w, h, pc);
      stride   = pred.row_stride();
      data_len = pred.data_bytes();
      for (int f = 0; f < frames; f++) begin
        total = pred.frame_bytes();
        // a broken frame: stop somewhere inside the last one
        if (cut_at != 0 && f == frames - 1) begin
          total = (phase_no == 1) ? cut_at : $urandom_range(1, total);
        end
        for (int i = 0; i < total; i++) begin
          pos = i % stride;
          if ($urandom_range(0, 19) == 0) begin
            send_req(palette_req(8'($urandom)));
            random_items++;
          end
          if ($urandom_range(0, 49) == 0) wait_for_pixels(0);
          case (d)
            DEPTH_24BIT: begin
              if (pos < data_len && pos % 3 == 0) color = pick_color();
              value = (pos < data_len) ? color[8*(pos%3) +: 8] : 8'($urandom);
            end
            DEPTH_8BIT: value = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 15))
                                                              : 8'($urandom);
            default: value = 8'($urandom);
          endcase
          send_byte(value);
          random_items++;
        end
      end
      phase_no++;
    end
    steady = 1'b0;

    wait_for_pixels(TAIL_CYCLES);
    if (pred.expected_pixels.size() != 0) begin
      $error("%0d predicted pixels never came out", pred.expected_pixels.size());
    end
    $display("covered %0d setting phases and %0d random input transactions",
             phases, random_items);
    $display("checked %0d pixels, %0d frame ends, %0d with index_error set",
             pred.pixels_checked, pred.frame_ends, pred.bad_indexes);
    if (pred.mismatches == 0 && pred.expected_pixels.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
